### design/bptd_pkg.sv
// Shared constants, types and register codes for the block power tone detector.
`timescale 1ns / 1ps
`default_nettype none
package bptd_pkg;

	localparam int SAMPLE_BITS    = 12;
	localparam int MAX_BLOCK_LOG2 = 8;

	localparam int LG_W     = 4;
	localparam int CNT_W    = MAX_BLOCK_LOG2 + 1;
	localparam int SQ_W     = 2 * SAMPLE_BITS - 1;
	localparam int SUM_W    = SQ_W + MAX_BLOCK_LOG2;
	localparam int POWER_W  = 23;
	localparam int FLOOR_W  = 30;
	localparam int ALPHA_W  = 9;
	localparam int RATIO_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [LG_W-1:0]    LG_MAX    = LG_W'(MAX_BLOCK_LOG2);
	localparam logic [SUM_W-1:0]   POWER_MAX = SUM_W'(1) << (2 * SAMPLE_BITS - 2);
	localparam logic [FLOOR_W-1:0] FLOOR_MAX = {FLOOR_W{1'b1}};
	localparam logic [ALPHA_W-1:0] ALPHA_MAX = ALPHA_W'(256);

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FALL_ALPHA = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RISE_ALPHA = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ON_RATIO   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_RATIO  = 3'd4;

	// Finished block as handed from the accumulator to the floor and tone logic.
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [LG_W-1:0]  lg;
	} blk_t;

	typedef struct packed {
		logic [LG_W-1:0]    block_log2;
		logic [ALPHA_W-1:0] fall_alpha;
		logic [ALPHA_W-1:0] rise_alpha;
		logic [RATIO_W-1:0] on_ratio;
		logic [RATIO_W-1:0] off_ratio;
	} cfg_t;

endpackage
`default_nettype wire

### design/block_power_tone_detector.sv
// Top level of the block power tone detector: configuration registers and wiring.
`timescale 1ns / 1ps
`default_nettype none
// One signed sample is taken every clock cycle; each is squared and added into
// the running block sum, so the accumulator never stalls on its own. When
// 2^block_log2 samples (block_log2 limited to 8) are in, the block sum moves
// into a two-entry queue and the floor and tone sequencer handles it step by
// step: mean power, floor seed and weight choice, the weight multiply, the
// floor step, the ratio multiply and the threshold decision. One result per
// block then waits in an output register. Blocks of eight samples or more keep
// up with one sample per cycle while results are taken; smaller blocks are
// paced by the sequencer, and the sample input holds off while the queue is
// full. Configuration writes take effect at once and need no wait.
module block_power_tone_detector (
	input  wire                                         clk,
	input  wire                                         arst_n,
	input  wire                                         in_valid,
	output logic                                        in_ready,
	input  wire logic signed [bptd_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                        out_valid,
	input  wire                                         out_ready,
	output logic                                        tone_present,
	output logic [bptd_pkg::POWER_W-1:0]                block_power,
	output logic [bptd_pkg::FLOOR_W-1:0]                floor_level,
	input  wire                                         cfg_write,
	input  wire logic [bptd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [bptd_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import bptd_pkg::*;

	cfg_t cfg_q;
	blk_t push_data;
	blk_t pop_data;
	logic push_valid;
	logic push_ready;
	logic pop_valid;
	logic pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_log2 <= LG_W'(6);
			cfg_q.fall_alpha <= ALPHA_W'(26);
			cfg_q.rise_alpha <= ALPHA_W'(5);
			cfg_q.on_ratio   <= RATIO_W'(1019);
			cfg_q.off_ratio  <= RATIO_W'(511);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_BLOCK_LOG2: cfg_q.block_log2 <= cfg_data[LG_W-1:0];
				CFG_FALL_ALPHA: cfg_q.fall_alpha <= cfg_data[ALPHA_W-1:0];
				CFG_RISE_ALPHA: cfg_q.rise_alpha <= cfg_data[ALPHA_W-1:0];
				CFG_ON_RATIO:   cfg_q.on_ratio   <= cfg_data[RATIO_W-1:0];
				CFG_OFF_RATIO:  cfg_q.off_ratio  <= cfg_data[RATIO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bptd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.block_log2 (cfg_q.block_log2),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	bptd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	bptd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.cfg          (cfg_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.tone_present (tone_present),
		.block_power  (block_power),
		.floor_level  (floor_level)
	);

endmodule
`default_nettype wire

### design/bptd_front.sv
// Sample accumulator: squares each sample and sums over one power block.
`timescale 1ns / 1ps
`default_nettype none
module bptd_front (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     in_valid,
	output logic                                    in_ready,
	input  wire logic signed [bptd_pkg::SAMPLE_BITS-1:0] sample,
	input  wire logic [bptd_pkg::LG_W-1:0]          block_log2,
	output logic                                    push_valid,
	input  wire                                     push_ready,
	output bptd_pkg::blk_t                          push_data
);
	import bptd_pkg::*;

	logic [SUM_W-1:0]         sum_q;
	logic [CNT_W-1:0]         count_q;
	logic [SAMPLE_BITS-1:0]   s_u;
	logic [SAMPLE_BITS-1:0]   mag;
	logic [2*SAMPLE_BITS-1:0] sq_full;
	logic [SUM_W-1:0]         sum_next;
	logic [CNT_W-1:0]         cnt_next;
	logic [LG_W-1:0]          lg_eff;
	logic [CNT_W-1:0]         size;
	logic                     accept;
	logic                     finish;

	assign in_ready = push_ready;
	assign accept   = in_valid & in_ready;

	always_comb begin
		s_u      = sample;
		// The most negative sample maps to its true magnitude, which still fits.
		mag      = s_u[SAMPLE_BITS-1] ? (~s_u + 1'b1) : s_u;
		sq_full  = {{SAMPLE_BITS{1'b0}}, mag} * {{SAMPLE_BITS{1'b0}}, mag};
		sum_next = sum_q + SUM_W'(sq_full[SQ_W-1:0]);
		cnt_next = count_q + 1'b1;
		lg_eff   = (block_log2 > LG_MAX) ? LG_MAX : block_log2;
		size     = CNT_W'(1) << lg_eff;
		finish   = (cnt_next >= size);
	end

	assign push_valid     = accept & finish;
	assign push_data.sum  = sum_next;
	assign push_data.lg   = lg_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (finish) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_next;
				count_q <= cnt_next;
			end
		end
	end

endmodule
`default_nettype wire

### design/bptd_queue.sv
// Two-entry queue of finished blocks between the accumulator and the floor logic.
`timescale 1ns / 1ps
`default_nettype none
module bptd_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push_valid,
	output logic                 push_ready,
	input  wire bptd_pkg::blk_t  push_data,
	output logic                 pop_valid,
	input  wire                  pop_ready,
	output bptd_pkg::blk_t       pop_data
);
	import bptd_pkg::*;

	blk_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

### design/bptd_back.sv
// Per-block sequencer: mean power, noise floor update and tone hysteresis.
`timescale 1ns / 1ps
`default_nettype none
module bptd_back (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                pop_valid,
	output logic                               pop_ready,
	input  wire bptd_pkg::blk_t                pop_data,
	input  wire bptd_pkg::cfg_t                cfg,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic                               tone_present,
	output logic [bptd_pkg::POWER_W-1:0]       block_power,
	output logic [bptd_pkg::FLOOR_W-1:0]       floor_level
);
	import bptd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MIX,
		S_MUL1,
		S_UPD,
		S_RAT,
		S_CMP
	} state_t;

	localparam int PROD_W  = ALPHA_W + FLOOR_W;
	localparam int RPROD_W = RATIO_W + FLOOR_W;

	state_t               state_q;
	logic [POWER_W-1:0]   p_q;
	logic [FLOOR_W-1:0]   floor_q;
	logic                 tone_q;
	logic                 below_q;
	logic                 upd_q;
	logic [ALPHA_W-1:0]   a_q;
	logic [FLOOR_W-1:0]   diff_q;
	logic [PROD_W-1:0]    prod_q;
	logic [RPROD_W-1:0]   rprod_q;

	logic [SUM_W-1:0]     p_sh;
	logic [POWER_W-1:0]   p_new;
	logic [FLOOR_W:0]     p8_w;
	logic [FLOOR_W-1:0]   p8;
	logic [FLOOR_W-1:0]   floor_eff;
	logic                 below;
	logic [ALPHA_W-1:0]   a_raw;
	logic [ALPHA_W-1:0]   a_sat;
	logic [FLOOR_W-1:0]   diff;
	logic [PROD_W-1:0]    prod;
	logic [PROD_W:0]      rnd;
	logic [PROD_W-8:0]    delta;
	logic [PROD_W-7:0]    up_sum;
	logic [FLOOR_W-1:0]   floor_upd;
	logic [FLOOR_W-1:0]   fl;
	logic [RATIO_W-1:0]   ratio;
	logic [RPROD_W-1:0]   rprod;
	logic [RPROD_W-1:0]   lhs;
	logic                 tone_next;
	logic                 out_free;

	assign pop_ready = (state_q == S_IDLE);
	assign out_free  = !out_valid || out_ready;

	always_comb begin
		// Mean power of the finished block, limited to the largest square.
		p_sh  = pop_data.sum >> pop_data.lg;
		p_new = (p_sh > POWER_MAX) ? POWER_MAX[POWER_W-1:0] : p_sh[POWER_W-1:0];

		p8_w      = {p_q, 8'b0};
		p8        = (p8_w > {1'b0, FLOOR_MAX}) ? FLOOR_MAX : p8_w[FLOOR_W-1:0];
		floor_eff = (floor_q == '0) ? p8 : floor_q;
		below     = (p8 < floor_eff);
		a_raw     = below ? cfg.fall_alpha : cfg.rise_alpha;
		a_sat     = (a_raw > ALPHA_MAX) ? ALPHA_MAX : a_raw;
		diff      = below ? (floor_eff - p8) : (p8 - floor_eff);

		prod = {{FLOOR_W{1'b0}}, a_q} * {{ALPHA_W{1'b0}}, diff_q};

		// Round to nearest, ties away from zero, before dropping the Q8 fraction.
		rnd    = {1'b0, prod_q} + (PROD_W + 1)'(128);
		delta  = rnd[PROD_W:8];
		up_sum = (PROD_W - 6)'(floor_q) + {1'b0, delta};
		if (!below_q) begin
			floor_upd = (up_sum > (PROD_W - 6)'(FLOOR_MAX)) ? FLOOR_MAX
			            : up_sum[FLOOR_W-1:0];
		end else begin
			floor_upd = (delta >= (PROD_W - 7)'(floor_q)) ? '0
			            : floor_q - delta[FLOOR_W-1:0];
		end

		fl    = (floor_q == '0) ? FLOOR_W'(1) : floor_q;
		ratio = tone_q ? cfg.off_ratio : cfg.on_ratio;
		rprod = {{FLOOR_W{1'b0}}, ratio} * {{RATIO_W{1'b0}}, fl};

		lhs = RPROD_W'({p_q, 16'b0});
		if (!tone_q) begin
			tone_next = (lhs >= rprod_q);
		end else begin
			tone_next = !(lhs <= rprod_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			floor_q      <= '0;
			tone_q       <= 1'b0;
			out_valid    <= 1'b0;
			p_q          <= '0;
			below_q      <= 1'b0;
			upd_q        <= 1'b0;
			a_q          <= '0;
			diff_q       <= '0;
			prod_q       <= '0;
			rprod_q      <= '0;
			tone_present <= 1'b0;
			block_power  <= '0;
			floor_level  <= '0;
		end else begin
			// In the decision step the valid is set again when the next result loads.
			if (out_valid && out_ready && state_q != S_CMP) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						p_q     <= p_new;
						state_q <= S_MIX;
					end
				end
				S_MIX: begin
					// A zero floor is seeded from this block before the update.
					floor_q <= floor_eff;
					below_q <= below;
					upd_q   <= !tone_q && (floor_eff != '0);
					a_q     <= a_sat;
					diff_q  <= diff;
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					prod_q  <= prod;
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (upd_q) begin
						floor_q <= floor_upd;
					end
					state_q <= S_RAT;
				end
				S_RAT: begin
					rprod_q <= rprod;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (out_free) begin
						tone_q       <= tone_next;
						tone_present <= tone_next;
						block_power  <= p_q;
						floor_level  <= floor_q;
						out_valid    <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_alpha_limited: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL1 |-> a_q <= ALPHA_MAX)
		else $error("floor weight above unity reached the multiplier");

	a_tone_only_in_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		tone_q != $past(tone_q) |-> $past(state_q) == S_CMP)
		else $error("tone flag changed outside the decision step");

	a_floor_only_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		floor_q != $past(floor_q) |-> ($past(state_q) == S_MIX || $past(state_q) == S_UPD))
		else $error("noise floor changed outside its update steps");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP && out_free |=> out_valid && state_q == S_IDLE)
		else $error("finished block did not produce a result");

endmodule
`default_nettype wire

### sim/tb_block_power_tone_detector.sv
// Self-checking testbench for the block power tone detector.
`timescale 1ns / 1ps

import bptd_pkg::*;

typedef struct {
	bit                 tone;
	logic [POWER_W-1:0] power;
	logic [FLOOR_W-1:0] floor_q8;
} block_result_t;

// Tracks the detector state per accepted sample and keeps the block results still owed.
class block_power_tracker;
	logic [SUM_W-1:0]   acc;
	logic [CNT_W-1:0]   count;
	logic [FLOOR_W-1:0] floor_q8;
	bit                 tone;
	cfg_t               regs;
	block_result_t      expected_blocks[$];
	int                 errors;

	function new();
		acc = '0;
		count = '0;
		floor_q8 = '0;
		tone = 1'b0;
		regs.block_log2 = LG_W'(6);
		regs.fall_alpha = ALPHA_W'(26);
		regs.rise_alpha = ALPHA_W'(5);
		regs.on_ratio = RATIO_W'(1019);
		regs.off_ratio = RATIO_W'(511);
		errors = 0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_BLOCK_LOG2: regs.block_log2 = data[LG_W-1:0];
			CFG_FALL_ALPHA: regs.fall_alpha = data[ALPHA_W-1:0];
			CFG_RISE_ALPHA: regs.rise_alpha = data[ALPHA_W-1:0];
			CFG_ON_RATIO:   regs.on_ratio = data[RATIO_W-1:0];
			CFG_OFF_RATIO:  regs.off_ratio = data[RATIO_W-1:0];
			default: ;
		endcase
	endfunction

	function void close_block(logic [LG_W-1:0] lg);
		longint unsigned p, p8, f, fl, a, diff, step, lhs;
		block_result_t res;
		p = longint'(acc) >> lg;
		if (p > POWER_MAX)
			p = POWER_MAX;
		p8 = p << 8;
		if (p8 > FLOOR_MAX)
			p8 = FLOOR_MAX;
		f = floor_q8;
		// A block of silence leaves the floor unseeded.
		if (f == 0)
			f = p8;
		if (!tone && f != 0) begin
			a = (p8 < f) ? regs.fall_alpha : regs.rise_alpha;
			if (a > ALPHA_MAX)
				a = ALPHA_MAX;
			if (p8 >= f) begin
				diff = p8 - f;
				step = (a * diff + 128) >> 8;
				f = f + step;
				if (f > FLOOR_MAX)
					f = FLOOR_MAX;
			end else begin
				diff = f - p8;
				step = (a * diff + 128) >> 8;
				f = (step >= f) ? 0 : f - step;
			end
		end
		floor_q8 = f[FLOOR_W-1:0];
		fl = (f > 0) ? f : 1;
		lhs = p << 16;
		if (!tone && lhs >= longint'(regs.on_ratio) * fl)
			tone = 1'b1;
		else if (tone && lhs <= longint'(regs.off_ratio) * fl)
			tone = 1'b0;
		res.tone = tone;
		res.power = p[POWER_W-1:0];
		res.floor_q8 = floor_q8;
		expected_blocks.push_back(res);
		acc = '0;
		count = '0;
	endfunction

	function void take_sample(logic signed [SAMPLE_BITS-1:0] s);
		logic [SAMPLE_BITS-1:0] mag;
		logic [LG_W-1:0]        lg;
		mag = s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
		acc = acc + SUM_W'(mag) * SUM_W'(mag);
		count = count + 1'b1;
		lg = (regs.block_log2 > LG_MAX) ? LG_MAX : regs.block_log2;
		// A block shrunk below the samples already taken closes on this sample.
		if (count >= (CNT_W'(1) << lg))
			close_block(lg);
	endfunction

	function void check_block(logic tone_i, logic [POWER_W-1:0] power_i,
			logic [FLOOR_W-1:0] floor_i);
		block_result_t want;
		if (expected_blocks.size() == 0) begin
			$display("%0t: unexpected result: tone %b power %0d floor %0d",
				$time, tone_i, power_i, floor_i);
			errors++;
			return;
		end
		want = expected_blocks.pop_front();
		if (tone_i !== want.tone) begin
			$display("%0t: tone_present expected %b, got %b", $time, want.tone, tone_i);
			errors++;
		end
		if (power_i !== want.power) begin
			$display("%0t: block_power expected %0d, got %0d", $time, want.power, power_i);
			errors++;
		end
		if (floor_i !== want.floor_q8) begin
			$display("%0t: floor_level expected %0d, got %0d",
				$time, want.floor_q8, floor_i);
			errors++;
		end
	endfunction

	function int pending();
		return expected_blocks.size();
	endfunction
endclass

module tb_block_power_tone_detector;

	localparam int LIMIT_CYCLES  = 300000;
	localparam int SETTLE_CYCLES = 32;
	localparam int FULL_SCALE    = 1 << (SAMPLE_BITS - 1);

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          out_valid;
	logic                          out_ready;
	logic                          tone_present;
	logic [POWER_W-1:0]            block_power;
	logic [FLOOR_W-1:0]            floor_level;
	logic                          cfg_write;
	logic [CFG_IDX_W-1:0]          cfg_index;
	logic [CFG_DATA_W-1:0]         cfg_data;

	block_power_tracker tracker;
	int send_gap_pct;
	int stall_pct;
	int hold_cycles;
	int cycles;

	block_power_tone_detector dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tone_present(tone_present),
		.block_power(block_power),
		.floor_level(floor_level),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// A long hold-off takes priority over the random stalls.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready = 1'b0;
			hold_cycles--;
		end else begin
			out_ready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_block(tone_present, block_power, floor_level);
	end

	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		sample = s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.take_sample(s);
		@(negedge clk);
	endtask

	// The optional settle time adds idle cycles after the last owed result is checked.
	task automatic wait_drained(input bit settle);
		in_valid = 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		if (settle)
			repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_regs(input int unsigned lg, input int unsigned fall,
			input int unsigned rise, input int unsigned on, input int unsigned off);
		logic [CFG_IDX_W-1:0] idx[5];
		int unsigned          val[5];
		idx = '{CFG_BLOCK_LOG2, CFG_FALL_ALPHA, CFG_RISE_ALPHA, CFG_ON_RATIO, CFG_OFF_RATIO};
		val = '{lg, fall, rise, on, off};
		for (int i = 0; i < 5; i++) begin
			cfg_write = 1'b1;
			cfg_index = idx[i];
			cfg_data = val[i][CFG_DATA_W-1:0];
			@(posedge clk);
			tracker.write_reg(cfg_index, cfg_data);
			@(negedge clk);
		end
		cfg_write = 1'b0;
	endtask

	function automatic int unsigned pick_alpha();
		case ($urandom_range(5))
			0: return 0;
			1: return 256;
			2: return $urandom_range(257, 511);
			default: return $urandom_range(1, 64);
		endcase
	endfunction

	function automatic int unsigned pick_ratio(input int unsigned lo, input int unsigned hi);
		case ($urandom_range(5))
			0: return 0;
			1: return 65535;
			2: return $urandom_range(65535);
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	function automatic int pick_level();
		case ($urandom_range(9))
			0: return 0;
			1, 2, 3: return $urandom_range(1, 16);
			4, 5: return $urandom_range(17, 200);
			6, 7: return $urandom_range(201, 1200);
			default: return $urandom_range(1201, FULL_SCALE);
		endcase
	endfunction

	// Mostly bounded by the segment level, with an occasional full-range glitch.
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int amp);
		int v;
		if ($urandom_range(19) == 0) begin
			v = $urandom_range(2 * FULL_SCALE - 1);
		end else begin
			v = int'($urandom_range(2 * amp)) - amp;
			if (v > FULL_SCALE - 1)
				v = FULL_SCALE - 1;
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	task automatic run_phase(input int lg, input int items, input int gap, input int stall,
			input int hold, input bit pause_midway);
		int lg_eff;
		int left;
		int seg;
		int amp;
		wait_drained(1'b1);
		send_gap_pct = gap;
		stall_pct = stall;
		write_regs(lg, pick_alpha(), pick_alpha(), pick_ratio(600, 2500),
			pick_ratio(100, 600));
		hold_cycles = hold;
		lg_eff = (lg > MAX_BLOCK_LOG2) ? MAX_BLOCK_LOG2 : lg;
		left = items;
		// Runs of whole blocks at one level let the floor settle and the tone flag toggle.
		while (left > 0) begin
			amp = pick_level();
			seg = (1 << lg_eff) * $urandom_range(1, 6);
			if (seg > left)
				seg = left;
			repeat (seg) send_sample(pick_sample(amp));
			left -= seg;
			if (pause_midway && left <= items / 2) begin
				wait_drained(1'b0);
				pause_midway = 1'b0;
			end
		end
	endtask

	initial begin
		int lg_plan[10];
		tracker = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		out_ready = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_BLOCK_LOG2;
		cfg_data = '0;
		send_gap_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		cycles = 0;
		lg_plan = '{2, 0, 3, 1, 4, 2, 9, 0, 5, 3};
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Two-sample blocks: silence, full-scale seed, then a falling floor.
		write_regs(1, 26, 5, 1019, 511);
		send_sample(12'sd0);
		send_sample(12'sd0);
		send_sample(-12'sd2048);
		send_sample(-12'sd2048);
		send_sample(12'sd2047);
		send_sample(-12'sd1);
		send_sample(12'sd1);
		send_sample(12'sd0);

		// Oversized fall weight snaps the floor, then a loud block sets the tone.
		wait_drained(1'b1);
		write_regs(1, 511, 0, 1019, 511);
		send_sample(12'sd3);
		send_sample(-12'sd3);
		send_sample(12'sd100);
		send_sample(-12'sd100);
		send_sample(12'sd0);
		send_sample(12'sd0);

		// Zero set ratio and maximal clear ratio.
		wait_drained(1'b1);
		write_regs(1, 256, 300, 0, 65535);
		send_sample(12'sd1);
		send_sample(12'sd1);
		send_sample(12'sd5);
		send_sample(12'sd5);

		// Oversized block size, then a shrink mid-block with a saturating mean.
		wait_drained(1'b1);
		write_regs(15, 26, 5, 65535, 0);
		repeat (5) send_sample(-12'sd2048);
		wait_drained(1'b1);
		write_regs(1, 26, 5, 65535, 0);
		send_sample(-12'sd2048);

		for (int p = 0; p < 10; p++) begin
			case (p % 4)
				0: run_phase(lg_plan[p], (lg_plan[p] > 8) ? 300 : 140, 0, 0,
					(p == 0) ? 300 : 0, 1'b0);
				1: run_phase(lg_plan[p], (lg_plan[p] > 8) ? 300 : 140, 54, 0, 0, 1'b0);
				2: run_phase(lg_plan[p], (lg_plan[p] > 8) ? 300 : 140, 0, 54, 0, 1'b1);
				default: run_phase(lg_plan[p], (lg_plan[p] > 8) ? 300 : 140, 7, 7, 0,
					1'b0);
			endcase
		end

		wait_drained(1'b0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### files.f
design/bptd_pkg.sv
design/bptd_front.sv
design/bptd_queue.sv
design/bptd_back.sv
design/block_power_tone_detector.sv
sim/tb_block_power_tone_detector.sv
